// ----- hw/rtl/snt_pkg.sv -----
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types and constants for the sensor normalise/threshold block.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned FULL_SCALE    = 100;
  localparam int unsigned THRESH_RESET  = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINMAX,
    ST_MUL,
    ST_SCL_GO,
    ST_SCL_WAIT,
    ST_OUT
  } snt_state_e;

  // Lockstep control from the sequencer to every lane
  typedef struct packed {
    logic run_wr;     // run request accepted: write sample, update sum
    logic prime_wr;   // prime request accepted: fill window, seed min/max
    logic div_start;  // launch the lane divider on numerator / span
    logic minmax_en;  // widen min/max with the fresh average
    logic mul_en;     // form numerator and span
  } snt_ctrl_t;

endpackage

// ----- hw/rtl/snt_div.sv -----
// ----------------------------------------------------------------------------
// snt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module snt_div #(
  parameter int unsigned DW = 17,  // dividend / quotient width
  parameter int unsigned VW = 10   // divisor width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quot_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so VW bits hold it
      rem_d = ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// ----- hw/rtl/snt_lane.sv -----
// ----------------------------------------------------------------------------
// snt_lane
// One channel: sample window with running sum, reciprocal-multiply average,
// min/max tracking and the divider used for the scaling.
// ----------------------------------------------------------------------------
module snt_lane #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned PW          = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  snt_pkg::snt_ctrl_t         ctrl_i,
  input  logic [PW-1:0]              pos_i,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  output logic                       done_o,
  output logic [snt_pkg::LEVEL_W-1:0] level_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUM_W = SB + $clog2(WINDOW);
  localparam int unsigned DW    = SB + snt_pkg::LEVEL_W;
  // sum / WINDOW as a multiply by the rounded-up reciprocal, exact over SUM_W bits
  localparam int unsigned RSH   = SUM_W + $clog2(WINDOW);
  localparam int unsigned RW    = SUM_W + 2;
  localparam int unsigned PRW   = SUM_W + RW;
  localparam logic [RW-1:0]    RCP_C  =
    RW'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [SUM_W-1:0] WIN_C  = SUM_W'(WINDOW);
  localparam logic [DW-1:0]    FULL_C = DW'(snt_pkg::FULL_SCALE);

  logic [SB-1:0]    win_q [WINDOW];
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SB-1:0]    min_q, min_d, max_q, max_d;
  logic [SB-1:0]    avg_q;
  logic [DW-1:0]    num_q;
  logic [SB-1:0]    span_q;
  logic             zero_q;
  logic [DW-1:0]    quot;
  logic [PRW-1:0]   avg_prod;
  logic [SB-1:0]    avg_new;

  assign avg_prod = PRW'(sum_q) * PRW'(RCP_C);
  assign avg_new  = avg_prod[RSH +: SB];

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.prime_wr) begin
      sum_d = SUM_W'(sample_i) * WIN_C;
    end else if (ctrl_i.run_wr) begin
      sum_d = SUM_W'(({1'b0, sum_q} + (SUM_W + 1)'(sample_i))
                     - (SUM_W + 1)'(win_q[pos_i]));
    end
  end

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (ctrl_i.prime_wr) begin
      min_d = sample_i;
      max_d = sample_i;
    end else if (ctrl_i.minmax_en) begin
      if (avg_new < min_q) min_d = avg_new;
      if (avg_new > max_q) max_d = avg_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_q[k] <= '0;
      end
      sum_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else begin
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
      if (ctrl_i.prime_wr) begin
        for (int k = 0; k < WINDOW; k++) begin
          win_q[k] <= sample_i;
        end
      end else if (ctrl_i.run_wr) begin
        win_q[pos_i] <= sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.minmax_en) begin
      avg_q <= avg_new;
    end
    if (ctrl_i.mul_en) begin
      // avg already lies inside [min, max] after widening
      num_q  <= DW'(avg_q - min_q) * FULL_C;
      span_q <= max_q - min_q;
      zero_q <= max_q <= min_q;
    end
  end

  snt_div #(
    .DW (DW),
    .VW (SB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (span_q),
    .done_o     (done_o),
    .quot_o     (quot)
  );

  always_comb begin
    if (zero_q) begin
      level_o = '0;
    end else if (quot > FULL_C) begin
      level_o = snt_pkg::LEVEL_W'(snt_pkg::FULL_SCALE);
    end else begin
      level_o = quot[snt_pkg::LEVEL_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/snt_merge.sv -----
// ----------------------------------------------------------------------------
// snt_merge
// Gathers the lane levels, forms the threshold mask and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module snt_merge #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic [CHANNELS*snt_pkg::LEVEL_W-1:0]   levels_i,
  input  logic                                   cfg_we_i,
  input  logic [snt_pkg::LEVEL_W-1:0]            cfg_wdata_i,
  output logic                                   free_o,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [CHANNELS*8-1:0]                  m_axis_tdata_o
);

  localparam int unsigned LW = snt_pkg::LEVEL_W;

  logic [LW-1:0]         thr_q;
  logic                  vld_q;
  logic [CHANNELS*8-1:0] data_q;
  logic [CHANNELS-1:0]   mask;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mask[c] = levels_i[c*LW +: LW] >= thr_q;
    end
  end

  assign free_o          = !vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= LW'(snt_pkg::THRESH_RESET);
      vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (load_i) begin
        vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {mask, levels_i};
    end
  end

endmodule

// ----- hw/rtl/sensor_normalize_threshold.sv -----
// ----------------------------------------------------------------------------
// sensor_normalize_threshold
// Per-channel moving average, min/max normalisation to 0..100 and a
// threshold mask, one lane per channel with a shared sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  request                  tdata / tuser
//  s_axis    in   one frame of samples     samples / action
//  m_axis    out  one result per run frame levels + mask
//  cfg       in   level_threshold write    7-bit value
//
//  A run frame is dominated by the lane divider's one-bit-per-cycle
//  scaling pass; the window average is a reciprocal multiply.
//  A prime frame gives no result.
//  Reset clears windows, sums, min/max and write position; threshold to 80.
//  A finished result waits in the output register while the next frame is
//  taken; the lanes stall before loading it only if that register is full.
// ----------------------------------------------------------------------------
module sensor_normalize_threshold #(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  // samples: sample_0 .. sample_N-1, SAMPLE_BITS each, from bit 0 up
  input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // action: 0 run frame, 1 prime frame
  input  logic [0:0]                                s_axis_tuser_i,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // level_0 .. level_N-1 (7 bits each), then above_mask (CHANNELS bits)
  output logic [CHANNELS*8-1:0]                     m_axis_tdata_o,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  input  logic                                      cfg_we_i,
  input  logic [snt_pkg::LEVEL_W-1:0]               cfg_wdata_i
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned LW = snt_pkg::LEVEL_W;
  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  snt_pkg::snt_state_e state_q, state_d;
  snt_pkg::snt_ctrl_t  ctrl;
  logic [PW-1:0]       pos_q, pos_d;
  logic                accept;
  logic                run_acc, prime_acc;
  logic [CHANNELS-1:0] lane_done;
  logic                div_done;
  logic                free;
  logic                load;
  logic [CHANNELS*LW-1:0] levels;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign run_acc   = accept && !s_axis_tuser_i[0];
  assign prime_acc = accept && s_axis_tuser_i[0];
  assign div_done  = &lane_done;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      snt_pkg::ST_IDLE:     if (run_acc) state_d = snt_pkg::ST_MINMAX;
      snt_pkg::ST_MINMAX:   state_d = snt_pkg::ST_MUL;
      snt_pkg::ST_MUL:      state_d = snt_pkg::ST_SCL_GO;
      snt_pkg::ST_SCL_GO:   state_d = snt_pkg::ST_SCL_WAIT;
      snt_pkg::ST_SCL_WAIT: if (div_done) state_d = snt_pkg::ST_OUT;
      snt_pkg::ST_OUT:      if (free) state_d = snt_pkg::ST_IDLE;
      default:              state_d = snt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ctrl            = '0;
    load            = 1'b0;
    case (state_q)
      snt_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ctrl.run_wr     = run_acc;
        ctrl.prime_wr   = prime_acc;
      end
      snt_pkg::ST_MINMAX:   ctrl.minmax_en = 1'b1;
      snt_pkg::ST_MUL:      ctrl.mul_en    = 1'b1;
      snt_pkg::ST_SCL_GO:   ctrl.div_start = 1'b1;
      snt_pkg::ST_OUT:      load           = free;
      default: ;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (run_acc) begin
      pos_d = (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snt_pkg::ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    snt_lane #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SB),
      .PW          (PW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pos_i    (pos_q),
      .sample_i (s_axis_tdata_i[c*SB +: SB]),
      .done_o   (lane_done[c]),
      .level_o  (levels[c*LW +: LW])
    );
  end

  snt_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .levels_i        (levels),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ----- hw/rtl/snt_checker.sv -----
// ----------------------------------------------------------------------------
// snt_checker
// Port-level properties of the sensor normalise/threshold block.
// ----------------------------------------------------------------------------
module snt_checker #(
  parameter int unsigned CHANNELS    = 6
) (
  input logic                                      clk_i,
  input logic                                      rst_ni,
  input logic [0:0]                                s_axis_tuser_i,
  input logic                                      s_axis_tvalid_i,
  input logic                                      s_axis_tready_o,
  input logic [CHANNELS*8-1:0]                     m_axis_tdata_o,
  input logic                                      m_axis_tvalid_o,
  input logic                                      m_axis_tready_i
);

  localparam int unsigned LW = snt_pkg::LEVEL_W;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed under stall");

  // a prime frame never produces a result
  a_prime_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i[0] && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result after prime frame");

  // one run frame at a time
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !s_axis_tuser_i[0] |=> !s_axis_tready_o)
    else $error("ready while a run frame is in flight");

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lvl
    a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> m_axis_tdata_o[c*LW +: LW] <= LW'(snt_pkg::FULL_SCALE))
      else $error("level above full scale");
  end

endmodule

bind sensor_normalize_threshold snt_checker #(
  .CHANNELS    (CHANNELS)
) u_snt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
